/* rtl/lmpes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix pixel editor package
// Matrix geometry, button codes, transaction payload types and the pixel
// color step used by the editor; the checker shares the geometry and types.
// ----------------------------------------------------------------------------
package lmpes_pkg;

    localparam int ROWS   = 8;
    localparam int COLS   = 16;
    localparam int CELLS  = ROWS * COLS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int BIT_W  = $clog2(2 * ROWS);
    localparam int PIX_W  = 2;

    localparam int OUT_COL_W = 4;
    localparam int OUT_ROW_W = 3;

    localparam logic [2:0] CODE_UP     = 3'd1;
    localparam logic [2:0] CODE_LEFT   = 3'd3;
    localparam logic [2:0] CODE_RIGHT  = 3'd4;
    localparam logic [2:0] CODE_DOWN   = 3'd6;
    localparam logic [2:0] CODE_CENTER = 3'd7;

    localparam int BTN_UP     = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_LEFT   = 2;
    localparam int BTN_RIGHT  = 3;
    localparam int BTN_CENTER = 4;
    localparam int BTN_ACTION = 5;
    localparam int BTN_W      = 6;

    localparam logic [PIX_W-1:0] PIX_OFF      = 2'b00;
    localparam logic [PIX_W-1:0] PIX_GREEN    = 2'b01;
    localparam logic [PIX_W-1:0] PIX_RED      = 2'b10;
    localparam logic [PIX_W-1:0] PIX_GREEN_RED = 2'b11;

    typedef struct packed {
        logic       mode;
        logic [2:0] button_code;
        logic       action_pin;
    } in_t;

    typedef struct packed {
        logic [OUT_COL_W-1:0] column_select;
        logic                 row_bit;
        logic                 bit_valid;
        logic                 column_done;
        logic                 frame_done;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_col;
    } out_t;

    function automatic logic [PIX_W-1:0] pix_step(input logic [PIX_W-1:0] p);
        logic [PIX_W-1:0] n;
        case (p)
            PIX_OFF:       n = PIX_GREEN;
            PIX_GREEN:     n = PIX_GREEN_RED;
            PIX_GREEN_RED: n = PIX_RED;
            default:       n = PIX_OFF;
        endcase
        return n;
    endfunction

    function automatic logic [PIX_W-1:0] pix_reset(input logic [ADDR_W-1:0] a);
        return {a[ROW_W], a[0]};
    endfunction

endpackage

/* rtl/lmpes_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module lmpes_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/led_matrix_pixel_editor_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix pixel editor and scanner
// Button decoding, cursor movement, pixel editing and serial row scan-out
// for a two-color LED matrix.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock when the result side is not
// stalled, and returns one result per transaction in the order taken.
// Stage one decodes buttons, moves the cursor, advances the scan
// counters and issues a read of the pixel RAM; stage two gets the pixel,
// forwards a write made by the transaction just ahead, and writes back the
// next color on an action press; the output register holds the result. The
// pixel RAM has one read and one write port, and a flag per pixel makes an
// unwritten pixel read as its power-up pattern, so no clearing pass is needed.
module led_matrix_pixel_editor_scanner (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  lmpes_pkg::in_t    s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output lmpes_pkg::out_t   m_payload
);

    typedef struct packed {
        logic                            mode;
        logic                            action;
        logic [lmpes_pkg::ADDR_W-1:0]    addr;
        logic                            bit_sel;
        logic                            cdone;
        logic                            fdone;
        logic [lmpes_pkg::COL_W-1:0]     col_sel;
        logic [lmpes_pkg::ROW_W-1:0]     crow;
        logic [lmpes_pkg::COL_W-1:0]     ccol;
    } stage_t;

    logic                           s1_valid_reg;
    lmpes_pkg::in_t                 s1_data_reg;
    logic                           s2_valid_reg;
    stage_t                         s2_reg;
    logic                           fwd_reg;
    logic [lmpes_pkg::PIX_W-1:0]    fwd_data_reg;
    logic                           vld_reg;
    logic                           m_valid_reg;
    lmpes_pkg::out_t                m_payload_reg;

    logic [lmpes_pkg::CELLS-1:0]    pix_valid_reg;
    logic [lmpes_pkg::BTN_W-1:0]    prev_buttons_reg, prev_buttons_next;
    logic [lmpes_pkg::ROW_W-1:0]    cursor_row_reg, cursor_row_next;
    logic [lmpes_pkg::COL_W-1:0]    cursor_col_reg, cursor_col_next;
    logic [lmpes_pkg::COL_W-1:0]    scan_col_reg, scan_col_next;
    logic [lmpes_pkg::BIT_W-1:0]    scan_idx_reg, scan_idx_next;

    logic out_en, s2_en, s1_move, s2_write;
    logic [lmpes_pkg::BTN_W-1:0]    cur_btn, rise;
    logic [lmpes_pkg::ROW_W-1:0]    row_base;
    logic [lmpes_pkg::COL_W-1:0]    col_base, scol;
    logic [lmpes_pkg::BIT_W-1:0]    sidx;
    stage_t                         s1_res;
    logic [lmpes_pkg::PIX_W-1:0]    ram_rdata, pix_cur, pix_new;
    lmpes_pkg::out_t                result;

    assign out_en   = !m_valid_reg || m_ready;
    assign s2_en    = !s2_valid_reg || out_en;
    assign s_ready  = !s1_valid_reg || s2_en;
    assign s1_move  = s1_valid_reg && s2_en;
    assign s2_write = s2_valid_reg && out_en && s2_reg.action;

    always_comb begin
        cur_btn = '0;
        unique case (s1_data_reg.button_code)
            lmpes_pkg::CODE_UP:     cur_btn[lmpes_pkg::BTN_UP]     = 1'b1;
            lmpes_pkg::CODE_LEFT:   cur_btn[lmpes_pkg::BTN_LEFT]   = 1'b1;
            lmpes_pkg::CODE_RIGHT:  cur_btn[lmpes_pkg::BTN_RIGHT]  = 1'b1;
            lmpes_pkg::CODE_DOWN:   cur_btn[lmpes_pkg::BTN_DOWN]   = 1'b1;
            lmpes_pkg::CODE_CENTER: cur_btn[lmpes_pkg::BTN_CENTER] = 1'b1;
            default:                cur_btn = '0;
        endcase
        cur_btn[lmpes_pkg::BTN_ACTION] = !s1_data_reg.action_pin;
        rise = cur_btn & ~prev_buttons_reg;

        row_base = (int'(cursor_row_reg) >= lmpes_pkg::ROWS) ? '0 : cursor_row_reg;
        col_base = (int'(cursor_col_reg) >= lmpes_pkg::COLS) ? '0 : cursor_col_reg;
        scol     = (int'(scan_col_reg) >= lmpes_pkg::COLS) ? '0 : scan_col_reg;
        sidx     = (int'(scan_idx_reg) >= 2 * lmpes_pkg::ROWS) ? '0 : scan_idx_reg;

        cursor_row_next   = row_base;
        cursor_col_next   = col_base;
        prev_buttons_next = prev_buttons_reg;
        scan_col_next     = scol;
        scan_idx_next     = sidx;

        s1_res         = '0;
        s1_res.mode    = s1_data_reg.mode;
        s1_res.col_sel = scol;
        s1_res.bit_sel = sidx[0];

        if (s1_data_reg.mode) begin
            s1_res.addr = lmpes_pkg::ADDR_W'(int'(scol) * lmpes_pkg::ROWS
                                             + int'(sidx[lmpes_pkg::BIT_W-1:1]));
            if (sidx == lmpes_pkg::BIT_W'(2 * lmpes_pkg::ROWS - 1)) begin
                s1_res.cdone  = 1'b1;
                scan_idx_next = '0;
                if (scol == lmpes_pkg::COL_W'(lmpes_pkg::COLS - 1)) begin
                    s1_res.fdone  = 1'b1;
                    scan_col_next = '0;
                end else begin
                    scan_col_next = scol + 1'b1;
                end
            end else begin
                scan_idx_next = sidx + 1'b1;
            end
            cursor_row_next = cursor_row_reg;
            cursor_col_next = cursor_col_reg;
        end else begin
            prev_buttons_next = cur_btn;
            if (rise[lmpes_pkg::BTN_UP]) begin
                cursor_row_next = (row_base == '0) ?
                    lmpes_pkg::ROW_W'(lmpes_pkg::ROWS - 1) : row_base - 1'b1;
            end else if (rise[lmpes_pkg::BTN_DOWN]) begin
                cursor_row_next = (row_base == lmpes_pkg::ROW_W'(lmpes_pkg::ROWS - 1)) ?
                    '0 : row_base + 1'b1;
            end else if (rise[lmpes_pkg::BTN_LEFT]) begin
                cursor_col_next = (col_base == '0) ?
                    lmpes_pkg::COL_W'(lmpes_pkg::COLS - 1) : col_base - 1'b1;
            end else if (rise[lmpes_pkg::BTN_RIGHT]) begin
                cursor_col_next = (col_base == lmpes_pkg::COL_W'(lmpes_pkg::COLS - 1)) ?
                    '0 : col_base + 1'b1;
            end
            s1_res.action = rise[lmpes_pkg::BTN_ACTION];
            s1_res.addr   = lmpes_pkg::ADDR_W'(int'(cursor_col_next) * lmpes_pkg::ROWS
                                               + int'(cursor_row_next));
        end
        s1_res.crow = cursor_row_next;
        s1_res.ccol = cursor_col_next;
    end

    lmpes_ram #(
        .WIDTH(lmpes_pkg::PIX_W),
        .DEPTH(lmpes_pkg::CELLS)
    ) u_pix_ram (
        .clk  (aclk),
        .we   (s2_write),
        .waddr(s2_reg.addr),
        .wdata(pix_new),
        .re   (s1_move),
        .raddr(s1_res.addr),
        .rdata(ram_rdata)
    );

    always_comb begin
        if (fwd_reg) begin
            pix_cur = fwd_data_reg;
        end else if (vld_reg) begin
            pix_cur = ram_rdata;
        end else begin
            pix_cur = lmpes_pkg::pix_reset(s2_reg.addr);
        end
        pix_new = lmpes_pkg::pix_step(pix_cur);

        result               = '0;
        result.column_select = lmpes_pkg::OUT_COL_W'(s2_reg.col_sel);
        result.cursor_row    = lmpes_pkg::OUT_ROW_W'(s2_reg.crow);
        result.cursor_col    = lmpes_pkg::OUT_COL_W'(s2_reg.ccol);
        if (s2_reg.mode) begin
            result.row_bit     = s2_reg.bit_sel ? pix_cur[1] : pix_cur[0];
            result.bit_valid   = 1'b1;
            result.column_done = s2_reg.cdone;
            result.frame_done  = s2_reg.fdone;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            pix_valid_reg    <= '0;
            prev_buttons_reg <= '0;
            cursor_row_reg   <= '0;
            cursor_col_reg   <= '0;
            scan_col_reg     <= '0;
            scan_idx_reg     <= '0;
            fwd_reg          <= 1'b0;
        end else begin
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en) begin
                m_valid_reg <= s2_valid_reg;
            end
            if (s2_write) begin
                pix_valid_reg[s2_reg.addr] <= 1'b1;
            end
            if (s1_move) begin
                prev_buttons_reg <= prev_buttons_next;
                cursor_row_reg   <= cursor_row_next;
                cursor_col_reg   <= cursor_col_next;
                scan_col_reg     <= scan_col_next;
                scan_idx_reg     <= scan_idx_next;
                fwd_reg          <= s2_write && (s2_reg.addr == s1_res.addr);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            s1_data_reg <= s_payload;
        end
        if (s1_move) begin
            s2_reg       <= s1_res;
            fwd_data_reg <= pix_new;
            vld_reg      <= pix_valid_reg[s1_res.addr];
        end
        if (out_en && s2_valid_reg) begin
            m_payload_reg <= result;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

/* rtl/lmpes_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix pixel editor checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module lmpes_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            m_valid,
    input logic            m_ready,
    input lmpes_pkg::out_t m_payload
);

    // A result that is not taken stays on the port unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result transaction changed while stalled");

    // A button sample result carries no scan bit and no scan marks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.bit_valid |->
            !m_payload.row_bit && !m_payload.column_done && !m_payload.frame_done)
        else $error("button sample result carries scan data");

    // The end of a frame is also the end of the last column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.frame_done |->
            m_payload.column_done &&
            (m_payload.column_select == lmpes_pkg::OUT_COL_W'(lmpes_pkg::COLS - 1)))
        else $error("frame end outside the last column");

    // No result is offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered right after reset");

endmodule

bind led_matrix_pixel_editor_scanner lmpes_checker u_lmpes_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_payload(m_payload)
);

/* tb/led_matrix_pixel_editor_scanner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED matrix pixel editor and scanner testbench
// Drives button samples and scan ticks through the input channel with random
// gaps and output stalls, including one long output hold-off. It predicts
// every result from its own model of the cursor, the button edge detection,
// the pixel colors and the scan counters. Each result is checked field by
// field against the oldest expected result.
// ----------------------------------------------------------------------------
module led_matrix_pixel_editor_scanner_tb;

    localparam logic MODE_BUTTON = 1'b0;
    localparam logic MODE_SCAN   = 1'b1;
    localparam logic PIN_PRESSED  = 1'b0;
    localparam logic PIN_RELEASED = 1'b1;
    localparam logic [2:0] CODE_NONE_A = 3'd0;
    localparam logic [2:0] CODE_NONE_B = 3'd2;
    localparam logic [2:0] CODE_NONE_C = 3'd5;

    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_AT      = 150;
    localparam int LONG_HOLD    = 250;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    class pixel_scan_scoreboard;
        logic [lmpes_pkg::PIX_W-1:0] pixels[lmpes_pkg::CELLS];
        logic [lmpes_pkg::BTN_W-1:0] held;
        int cur_row;
        int cur_col;
        int scan_col;
        int scan_idx;
        lmpes_pkg::out_t pending[$];
        int errors;
        int accepted;
        int scans;
        int frames;
        int moves;
        int edits;

        function new();
            for (int c = 0; c < lmpes_pkg::COLS; c++) begin
                for (int r = 0; r < lmpes_pkg::ROWS; r++) begin
                    pixels[c * lmpes_pkg::ROWS + r] = {c[0], r[0]};
                end
            end
            held = '0;
            cur_row = 0;
            cur_col = 0;
            scan_col = 0;
            scan_idx = 0;
            errors = 0;
            accepted = 0;
            scans = 0;
            frames = 0;
            moves = 0;
            edits = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) begin
                $display("[%0t] mismatch: %s", $realtime, what);
            end
        endtask

        task note_input(lmpes_pkg::in_t t);
            lmpes_pkg::out_t r;
            logic [lmpes_pkg::BTN_W-1:0] now;
            logic [lmpes_pkg::BTN_W-1:0] rise;
            logic [lmpes_pkg::PIX_W-1:0] p;
            int a;
            r = '0;
            accepted++;
            if (t.mode == MODE_SCAN) begin
                scans++;
                p = pixels[scan_col * lmpes_pkg::ROWS + scan_idx / 2];
                r.row_bit = (scan_idx % 2 == 1) ? p[1] : p[0];
                r.bit_valid = 1'b1;
                r.column_select = scan_col[lmpes_pkg::OUT_COL_W-1:0];
                if (scan_idx == 2 * lmpes_pkg::ROWS - 1) begin
                    r.column_done = 1'b1;
                    scan_idx = 0;
                    if (scan_col == lmpes_pkg::COLS - 1) begin
                        r.frame_done = 1'b1;
                        scan_col = 0;
                        frames++;
                    end else begin
                        scan_col++;
                    end
                end else begin
                    scan_idx++;
                end
            end else begin
                now = '0;
                now[lmpes_pkg::BTN_UP]     = (t.button_code == lmpes_pkg::CODE_UP);
                now[lmpes_pkg::BTN_DOWN]   = (t.button_code == lmpes_pkg::CODE_DOWN);
                now[lmpes_pkg::BTN_LEFT]   = (t.button_code == lmpes_pkg::CODE_LEFT);
                now[lmpes_pkg::BTN_RIGHT]  = (t.button_code == lmpes_pkg::CODE_RIGHT);
                now[lmpes_pkg::BTN_CENTER] = (t.button_code == lmpes_pkg::CODE_CENTER);
                now[lmpes_pkg::BTN_ACTION] = (t.action_pin == PIN_PRESSED);
                rise = now & ~held;
                held = now;
                if (rise[lmpes_pkg::BTN_UP]) begin
                    cur_row = (cur_row == 0) ? lmpes_pkg::ROWS - 1 : cur_row - 1;
                    moves++;
                end else if (rise[lmpes_pkg::BTN_DOWN]) begin
                    cur_row = (cur_row == lmpes_pkg::ROWS - 1) ? 0 : cur_row + 1;
                    moves++;
                end else if (rise[lmpes_pkg::BTN_LEFT]) begin
                    cur_col = (cur_col == 0) ? lmpes_pkg::COLS - 1 : cur_col - 1;
                    moves++;
                end else if (rise[lmpes_pkg::BTN_RIGHT]) begin
                    cur_col = (cur_col == lmpes_pkg::COLS - 1) ? 0 : cur_col + 1;
                    moves++;
                end
                if (rise[lmpes_pkg::BTN_ACTION]) begin
                    a = cur_col * lmpes_pkg::ROWS + cur_row;
                    case (pixels[a])
                        lmpes_pkg::PIX_OFF:       pixels[a] = lmpes_pkg::PIX_GREEN;
                        lmpes_pkg::PIX_GREEN:     pixels[a] = lmpes_pkg::PIX_GREEN_RED;
                        lmpes_pkg::PIX_GREEN_RED: pixels[a] = lmpes_pkg::PIX_RED;
                        default:                  pixels[a] = lmpes_pkg::PIX_OFF;
                    endcase
                    edits++;
                end
                r.column_select = scan_col[lmpes_pkg::OUT_COL_W-1:0];
            end
            r.cursor_row = cur_row[lmpes_pkg::OUT_ROW_W-1:0];
            r.cursor_col = cur_col[lmpes_pkg::OUT_COL_W-1:0];
            pending.push_back(r);
        endtask

        task check_field(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                report($sformatf("%s expected %0d got %0d", name, exp_v, got_v));
            end
        endtask

        task check_result(lmpes_pkg::out_t got);
            lmpes_pkg::out_t e;
            if (pending.size() == 0) begin
                report($sformatf("result %h arrived with nothing expected", got));
            end else begin
                e = pending.pop_front();
                if ($isunknown(got)) begin
                    report($sformatf("result %h has unknown bits", got));
                end
                check_field("column_select", e.column_select, got.column_select);
                check_field("row_bit", e.row_bit, got.row_bit);
                check_field("bit_valid", e.bit_valid, got.bit_valid);
                check_field("column_done", e.column_done, got.column_done);
                check_field("frame_done", e.frame_done, got.frame_done);
                check_field("cursor_row", e.cursor_row, got.cursor_row);
                check_field("cursor_col", e.cursor_col, got.cursor_col);
            end
        endtask
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    lmpes_pkg::in_t  s_payload;
    logic m_valid;
    logic m_ready;
    lmpes_pkg::out_t m_payload;

    pixel_scan_scoreboard board;
    int cycle_count = 0;

    led_matrix_pixel_editor_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic lmpes_pkg::in_t make_item(logic mode, logic [2:0] code, logic pin);
        lmpes_pkg::in_t t;
        t.mode = mode;
        t.button_code = code;
        t.action_pin = pin;
        return t;
    endfunction

    task automatic send_item(lmpes_pkg::in_t t);
        int gap;
        gap = 0;
        if ((board.accepted % 100) >= 25 && $urandom_range(0, 99) < 25) begin
            gap = gap_length();
        end
        repeat (gap) begin
            @(negedge aclk);
            s_valid = 1'b0;
            s_payload = lmpes_pkg::in_t'($urandom);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_payload = t;
        do @(posedge aclk); while (!s_ready);
        board.note_input(t);
    endtask

    task automatic send_scans(int n);
        repeat (n) send_item(make_item(MODE_SCAN, 3'($urandom), 1'($urandom)));
    endtask

    task automatic send_button(logic [2:0] code, logic pin);
        send_item(make_item(MODE_BUTTON, code, pin));
    endtask

    function automatic logic [2:0] idle_code();
        case ($urandom_range(0, 2))
            0:       return CODE_NONE_A;
            1:       return CODE_NONE_B;
            default: return CODE_NONE_C;
        endcase
    endfunction

    function automatic logic [2:0] press_code();
        case ($urandom_range(0, 5))
            0:       return lmpes_pkg::CODE_UP;
            1:       return lmpes_pkg::CODE_DOWN;
            2:       return lmpes_pkg::CODE_LEFT;
            3:       return lmpes_pkg::CODE_RIGHT;
            4:       return lmpes_pkg::CODE_CENTER;
            default: return idle_code();
        endcase
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("FAIL led_matrix_pixel_editor_scanner");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_payload);
        end
    end

    initial begin
        int stall;
        bit held_off;
        stall = 0;
        held_off = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!held_off && board.accepted >= HOLD_AT) begin
                held_off = 1;
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                stall--;
            end else begin
                m_ready = 1'b1;
                if (cycle_count[7:6] != 2'b00 && $urandom_range(0, 99) < 15) begin
                    stall = gap_length();
                end
            end
        end
    end

    initial begin
        int kind;
        int start;
        logic [2:0] code;
        board = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_payload = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Wraparound at both cursor edges, held buttons, unused codes and a
        // full four-step color cycle on one pixel.
        send_scans(2);
        send_button(lmpes_pkg::CODE_UP, PIN_RELEASED);
        send_button(lmpes_pkg::CODE_UP, PIN_RELEASED);
        send_button(CODE_NONE_A, PIN_RELEASED);
        send_button(lmpes_pkg::CODE_LEFT, PIN_RELEASED);
        send_button(lmpes_pkg::CODE_RIGHT, PIN_RELEASED);
        send_button(lmpes_pkg::CODE_DOWN, PIN_RELEASED);
        send_button(lmpes_pkg::CODE_CENTER, PIN_PRESSED);
        send_button(CODE_NONE_B, PIN_PRESSED);
        send_button(CODE_NONE_C, PIN_RELEASED);
        send_button(CODE_NONE_A, PIN_PRESSED);
        send_scans(1);
        send_button(CODE_NONE_A, PIN_PRESSED);
        send_button(CODE_NONE_A, PIN_RELEASED);
        send_button(CODE_NONE_A, PIN_PRESSED);
        send_button(CODE_NONE_A, PIN_RELEASED);
        send_button(CODE_NONE_A, PIN_PRESSED);
        send_button(CODE_NONE_A, PIN_RELEASED);
        send_scans(3);

        start = board.accepted;
        while (board.accepted - start < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                send_scans($urandom_range(1, 24));
            end else if (kind < 85) begin
                code = press_code();
                send_button(code, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 2)) send_button(code, 1'($urandom_range(0, 1)));
                send_button(idle_code(), PIN_RELEASED);
            end else begin
                send_button(3'($urandom), 1'($urandom));
            end
        end
        @(negedge aclk);
        s_valid = 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d transactions: %0d scan bits over %0d full frames,",
                 board.accepted, board.scans, board.frames);
        $display("%0d cursor moves and %0d pixel edits.", board.moves, board.edits);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASS led_matrix_pixel_editor_scanner");
        end else begin
            $display("%0d mismatches, %0d results missing.",
                     board.errors, board.pending.size());
            $display("FAIL led_matrix_pixel_editor_scanner");
        end
        $finish;
    end

endmodule
